### hw/rtl/query_score_average_core_assert.svh
// Assertion helpers for the core file, which checks its own logic.
// Every check samples on the rising edge of clock and is off during reset.
`ifndef QUERY_SCORE_AVERAGE_CORE_ASSERT_SVH
`define QUERY_SCORE_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication.
`define QSA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define QSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hw/rtl/qsa_pkg.sv
`default_nettype none

package qsa_pkg;

   localparam int MAX_QUERIES = 64;
   localparam int SCORE_BITS  = 10;
   localparam int CNT_BITS    = $clog2(MAX_QUERIES + 1);
   localparam int SUM_BITS    = 20;
   localparam int OUT_BITS    = 13;
   localparam int MINREQ_BITS = 7;
   localparam int CMP_BITS    = (CNT_BITS > MINREQ_BITS) ? CNT_BITS : MINREQ_BITS;

   localparam int ZERO_POINT  = 320;
   localparam int OFFSET      = 100;
   localparam int NEG_DEFAULT = 640;

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   // Squared-distance transform widths. The divide by OFFSET is a multiply by
   // a rounded-up reciprocal; the extra 7 bits of shift keep it exact.
   localparam int A_BITS      = SCORE_BITS + 1;
   localparam int SQ_BITS     = 2 * A_BITS;
   localparam int RECIP_SHIFT = SQ_BITS + 7;
   localparam int RECIP_BITS  = RECIP_SHIFT - 6;
   localparam int PROD_BITS   = SQ_BITS + RECIP_BITS;
   localparam int QUOT_BITS   = SQ_BITS - 6;
   localparam int T_BITS      = QUOT_BITS + 1;
   localparam int ADD_BITS    = ((SUM_BITS > T_BITS) ? SUM_BITS : T_BITS) + 1;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(OFFSET) - 64'd1) / 64'(OFFSET);
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

   // Gene queue and divider.
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
   localparam int DIV_STEPS  = SUM_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = MINREQ_BITS;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SQUARE_MODE   = 2'd0,
      CSR_NEGATIVE_MODE = 2'd1,
      CSR_MIN_NEEDED    = 2'd2
   } qsa_csr_addr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } qsa_back_state_type;

   typedef struct packed {
      logic                   square_mode;
      logic                   negative_mode;
      logic [MINREQ_BITS-1:0] min_needed;
   } qsa_cfg_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]    sum;
      logic [CNT_BITS-1:0]    nonzero;
      logic [CNT_BITS-1:0]    items;
      logic                   negative;
      logic [MINREQ_BITS-1:0] min_req;
   } qsa_gene_type;

   typedef struct packed {
      logic         valid;
      qsa_gene_type gene;
   } qsa_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qsa_qstat_type;

   typedef struct packed {
      logic pop;
      logic emit;
   } qsa_back_stat_type;

endpackage

`default_nettype wire

### hw/rtl/qsa_if.sv
`default_nettype none

interface qsa_req_if import qsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SCORE_BITS-1:0] score;
   logic                  last;

   modport source (output valid, output score, output last, input ready);
   modport sink   (input valid, input score, input last, output ready);
endinterface

interface qsa_rsp_if import qsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] gene_score;
   logic                below_minimum;

   modport source (output valid, output gene_score, output below_minimum, input ready);
   modport sink   (input valid, input gene_score, input below_minimum, output ready);
endinterface

interface qsa_csr_if import qsa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] addr;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/query_score_average_core.sv
`default_nettype none
// Channel   Role      Fields                         Handshake
// req_ch    input     score[9:0], last               valid/ready
// rsp_ch    output    gene_score[12:0], below_minimum valid/ready
// csr_ch    config    addr[1:0], wdata[6:0]          valid/ready, ready always high
//
// The front takes one score item per cycle while not stalled and runs it
// through a three-stage transform and accumulate pipeline; a closing item
// enters the gene queue. The back retires one gene at a time: pop, 20 steps
// of the single-bit restoring divider, emit; a default skips the divider.
// Reset is synchronous and active high; it clears all control state and the
// accumulators, and sets the minimum nonzero count to 1.
// The front stalls only when a closing item meets a full two-entry queue; the
// result register holds its item until the consumer takes it.

`include "query_score_average_core_assert.svh"

module query_score_average_core import qsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qsa_req_if.sink   req_ch,
   qsa_rsp_if.source rsp_ch,
   qsa_csr_if.sink   csr_ch
);

   // Configuration registers. The user must write them only while the block
   // is idle; the block does not enforce it. The front reads them directly.
   logic                   square_mode_ff, square_mode_in;
   logic                   negative_mode_ff, negative_mode_in;
   logic [MINREQ_BITS-1:0] min_needed_ff, min_needed_in;
   qsa_cfg_type            cfg;

   qsa_push_type           push;
   qsa_gene_type           head;
   qsa_qstat_type          qstat;
   qsa_back_stat_type      bstat;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      square_mode_in   = square_mode_ff;
      negative_mode_in = negative_mode_ff;
      min_needed_in    = min_needed_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.addr)
            CSR_SQUARE_MODE:   square_mode_in   = csr_ch.wdata[0];
            CSR_NEGATIVE_MODE: negative_mode_in = csr_ch.wdata[0];
            CSR_MIN_NEEDED:    min_needed_in    = csr_ch.wdata;
            default: begin
               // Writes to unused addresses are dropped.
               square_mode_in = square_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_mode_ff   <= 1'b0;
         negative_mode_ff <= 1'b0;
         min_needed_ff    <= MINREQ_BITS'(1);
      end else begin
         square_mode_ff   <= square_mode_in;
         negative_mode_ff <= negative_mode_in;
         min_needed_ff    <= min_needed_in;
      end
   end

   assign cfg.square_mode   = square_mode_ff;
   assign cfg.negative_mode = negative_mode_ff;
   assign cfg.min_needed    = min_needed_ff;

   // Front: accept, transform and accumulate scores of the open gene.
   qsa_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg),
      .qstat  (qstat),
      .push   (push)
   );

   // Closed genes wait here until the back is free.
   qsa_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (bstat.pop),
      .head  (head),
      .qstat (qstat)
   );

   // Back: pick the divisor or the default, divide, and present the result.
   qsa_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .qstat  (qstat),
      .bstat  (bstat),
      .rsp_ch (rsp_ch)
   );

   // A closed gene must never be lost to a full queue.
   `QSA_ASSERT_NOW(a_no_push_when_full, push.valid, !qstat.full)
   // The back never takes a gene from an empty queue.
   `QSA_ASSERT_NOW(a_no_pop_when_empty, bstat.pop, !qstat.empty)
   // A result appears on the port only after the back hands one over.
   `QSA_ASSERT_NOW(a_rsp_from_emit, $rose(rsp_ch.valid), $past(bstat.emit))
   // A handed-over result is always on the port the next cycle.
   `QSA_ASSERT_NEXT(a_emit_shows, bstat.emit, rsp_ch.valid)

endmodule

`default_nettype wire

### hw/rtl/qsa_front.sv
`default_nettype none

module qsa_front import qsa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   qsa_req_if.sink      req_ch,
   input  qsa_cfg_type  cfg,
   input  qsa_qstat_type qstat,
   output qsa_push_type push
);

   logic                  adv;
   logic [A_BITS-1:0]     score_ext;
   logic [A_BITS-1:0]     zero_ext;
   logic [A_BITS-1:0]     zdist;
   logic [A_BITS-1:0]     shifted;
   logic [SQ_BITS-1:0]    square;

   logic                  s1_valid_ff, s1_valid_in;
   logic [SQ_BITS-1:0]    s1_sq_ff;
   logic [SCORE_BITS-1:0] s1_score_ff;
   logic                  s1_last_ff, s1_nz_ff, s1_square_ff;

   logic [PROD_BITS-1:0]  recip_prod;
   logic [QUOT_BITS-1:0]  quot;
   logic [T_BITS-1:0]     add_val;

   logic                  s2_valid_ff, s2_valid_in;
   logic [T_BITS-1:0]     s2_add_ff;
   logic                  s2_last_ff, s2_nz_ff;

   logic [SUM_BITS-1:0]   sum_ff, sum_in, sum_new;
   logic [CNT_BITS-1:0]   nz_ff, nz_in, nz_new;
   logic [CNT_BITS-1:0]   items_ff, items_in, items_new;
   logic [ADD_BITS-1:0]   wide_sum;

   // The whole front moves together; it only stops when a closing item
   // meets a full queue.
   assign adv          = !(s2_valid_ff && s2_last_ff && qstat.full);
   assign req_ch.ready = adv;

   // Stage 1: distance from the zero point, offset and square.
   assign score_ext = A_BITS'(req_ch.score);
   assign zero_ext  = A_BITS'(ZERO_POINT);
   assign zdist     = (score_ext >= zero_ext) ? (score_ext - zero_ext)
                                              : (zero_ext - score_ext);
   assign shifted   = zdist + A_BITS'(OFFSET);
   assign square    = SQ_BITS'(shifted) * SQ_BITS'(shifted);
   assign s1_valid_in = adv ? (req_ch.valid && req_ch.ready) : s1_valid_ff;

   // Stage 2: exact floor divide by offset via reciprocal, or raw score.
   assign recip_prod  = PROD_BITS'(s1_sq_ff) * PROD_BITS'(RECIP);
   assign quot        = recip_prod[PROD_BITS-1 -: QUOT_BITS];
   assign add_val     = s1_square_ff ? (T_BITS'(quot) + T_BITS'(ZERO_POINT))
                                     : T_BITS'(s1_score_ff);
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   // Stage 3: accumulate, close the gene into the queue.
   always_comb begin
      sum_new   = sum_ff;
      nz_new    = nz_ff;
      items_new = items_ff;
      wide_sum  = ADD_BITS'(sum_ff) + ADD_BITS'(s2_add_ff);
      if (s2_valid_ff && (items_ff < CNT_BITS'(MAX_QUERIES))) begin
         items_new = items_ff + CNT_BITS'(1);
         if (s2_nz_ff) begin
            sum_new = (wide_sum > ADD_BITS'(SUM_MAX)) ? SUM_MAX : wide_sum[SUM_BITS-1:0];
            nz_new  = nz_ff + CNT_BITS'(1);
         end
      end

      push.valid         = adv && s2_valid_ff && s2_last_ff;
      push.gene.sum      = sum_new;
      push.gene.nonzero  = nz_new;
      push.gene.items    = items_new;
      push.gene.negative = cfg.negative_mode;
      push.gene.min_req  = cfg.min_needed;

      sum_in   = sum_ff;
      nz_in    = nz_ff;
      items_in = items_ff;
      if (push.valid) begin
         sum_in   = '0;
         nz_in    = '0;
         items_in = '0;
      end else if (adv && s2_valid_ff) begin
         sum_in   = sum_new;
         nz_in    = nz_new;
         items_in = items_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         nz_ff       <= '0;
         items_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
         nz_ff       <= nz_in;
         items_ff    <= items_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sq_ff     <= square;
         s1_score_ff  <= req_ch.score;
         s1_last_ff   <= req_ch.last;
         s1_nz_ff     <= (req_ch.score != '0);
         s1_square_ff <= cfg.square_mode;
         s2_add_ff    <= add_val;
         s2_last_ff   <= s1_last_ff;
         s2_nz_ff     <= s1_nz_ff;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/qsa_queue.sv
`default_nettype none

module qsa_queue import qsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  qsa_push_type  push,
   input  logic          pop,
   output qsa_gene_type  head,
   output qsa_qstat_type qstat
);

   qsa_gene_type         entries_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_BITS'(QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = entries_ff[rd_ptr_ff];
   assign do_push     = push.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.gene;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/qsa_back.sv
`default_nettype none

module qsa_back import qsa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  qsa_gene_type      head,
   input  qsa_qstat_type     qstat,
   output qsa_back_stat_type bstat,
   qsa_rsp_if.source         rsp_ch
);

   qsa_back_state_type     state_ff, state_in;
   logic [SUM_BITS-1:0]    quo_ff, quo_in;
   logic [CNT_BITS-1:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0]    div_ff, div_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   flag_ff, flag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]    rsp_score_ff;
   logic                   rsp_flag_ff;

   logic [MINREQ_BITS-1:0] req_eff;
   logic                   by_items;
   logic                   use_default;
   logic [CNT_BITS:0]      trial;
   logic [OUT_BITS-1:0]    result;

   assign req_eff  = (head.min_req == '0) ? MINREQ_BITS'(1) : head.min_req;
   assign by_items = (req_eff == MINREQ_BITS'(1));
   assign use_default = (head.nonzero == '0) ||
      (!by_items && (CMP_BITS'(head.nonzero) < CMP_BITS'(req_eff)));
   assign trial  = {rem_ff, quo_ff[SUM_BITS-1]};
   assign result = (quo_ff > SUM_BITS'(OUT_MAX)) ? OUT_MAX : quo_ff[OUT_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      flag_in      = flag_ff;
      bstat.pop    = 1'b0;
      bstat.emit   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               bstat.pop = 1'b1;
               if (use_default) begin
                  quo_in   = head.negative ? SUM_BITS'(NEG_DEFAULT) : '0;
                  flag_in  = 1'b1;
                  state_in = BK_EMIT;
               end else begin
                  quo_in   = head.sum;
                  rem_in   = '0;
                  div_in   = by_items ? head.items : head.nonzero;
                  step_in  = '0;
                  flag_in  = 1'b0;
                  state_in = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (trial >= {1'b0, div_ff}) begin
               rem_in = CNT_BITS'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[CNT_BITS-1:0];
               quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               bstat.emit = 1'b1;
               state_in   = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = bstat.emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      flag_ff <= flag_in;
      if (bstat.emit) begin
         rsp_score_ff <= result;
         rsp_flag_ff  <= flag_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.gene_score    = rsp_score_ff;
   assign rsp_ch.below_minimum = rsp_flag_ff;

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

// Testbench for query_score_average_core.
// Score items are driven on the request channel, and each one is fed to a
// scoreboard model of the gene accumulator as soon as the core accepts it.
// Every closing item queues one expected gene result. A monitor process pops
// that queue for each result the core hands over and compares it field by
// field.
module testbench import qsa_pkg::*; ();

   // The slowest legal run is one result per item. Each of those passes the
   // back end's pop, divider steps and emit, plus stalls on both sides, so this
   // limit leaves a wide margin.
   localparam int LIMIT_CYCLES = 500000;
   // Drain time for the front pipeline, two-entry gene queue and divider.
   localparam int DRAIN_CYCLES = 60;
   localparam int IDLE_PCT     = 25;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASES       = 8;
   localparam int STEADY_PHASE = 2;

   typedef struct {
      logic [OUT_BITS-1:0] gene_score;
      logic                below_minimum;
   } gene_result_type;

   logic clock = 1'b0;
   logic reset;

   qsa_req_if req_ch ();
   qsa_rsp_if rsp_ch ();
   qsa_csr_if csr_ch ();

   query_score_average_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Scoreboard copy of the register file and of the per-gene accumulators.
   qsa_cfg_type         cfg_model;
   logic [SUM_BITS-1:0] gene_sum;
   int unsigned         gene_nonzero;
   int unsigned         gene_items;

   gene_result_type expected_genes[$];
   int              errors = 0;
   int              cycles = 0;
   // When this is set, neither side idles. The random part sets it for one
   // whole phase.
   bit              steady = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // The result consumer stalls at random unless the steady stretch is on.
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
      errors++;
   endtask

   // Squared distance from the zero point, with the offset folded in. The
   // division is an exact integer floor.
   function automatic int unsigned squared_distance(logic [SCORE_BITS-1:0] v);
      int unsigned gap;
      int unsigned shifted;
      gap     = (v >= ZERO_POINT) ? (v - ZERO_POINT) : (ZERO_POINT - v);
      shifted = gap + OFFSET;
      return (shifted * shifted) / OFFSET + ZERO_POINT;
   endfunction

   // Accumulates one accepted score item. When the gene closes, this works
   // out the averaged score it must produce.
   function automatic void accumulate_score(logic [SCORE_BITS-1:0] s, logic closing);
      int unsigned     addend;
      int unsigned     total;
      int unsigned     needed;
      int unsigned     quotient;
      gene_result_type res;
      // Items past the query limit are dropped, but their last flag still
      // closes the gene.
      if (gene_items < MAX_QUERIES) begin
         gene_items++;
         if (s != 0) begin
            addend   = cfg_model.square_mode ? squared_distance(s) : s;
            total    = gene_sum + addend;
            gene_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_BITS-1:0];
            gene_nonzero++;
         end
      end
      if (closing) begin
         // A minimum of zero behaves like a minimum of one.
         needed = (cfg_model.min_needed == 0) ? 1 : cfg_model.min_needed;
         if (gene_nonzero == 0 || (needed != 1 && gene_nonzero < needed)) begin
            quotient          = cfg_model.negative_mode ? NEG_DEFAULT : 0;
            res.below_minimum = 1'b1;
         end else begin
            // With a minimum of one, the divisor is the item count, zeros included.
            quotient          = gene_sum / ((needed == 1) ? gene_items : gene_nonzero);
            res.below_minimum = 1'b0;
         end
         res.gene_score = (quotient > OUT_MAX) ? OUT_MAX : quotient[OUT_BITS-1:0];
         expected_genes.insert(expected_genes.size(), res);
         gene_sum     = '0;
         gene_nonzero = 0;
         gene_items   = 0;
      end
   endfunction

   // The monitor checks results in order against the oldest expected gene.
   always @(posedge clock) begin : check_results
      gene_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_genes.size() == 0) begin
            report_mismatch("unexpected gene result, gene_score", rsp_ch.gene_score, 0);
         end else begin
            want = expected_genes.pop_front();
            if (rsp_ch.gene_score !== want.gene_score)
               report_mismatch("gene_score", rsp_ch.gene_score, want.gene_score);
            if (rsp_ch.below_minimum !== want.below_minimum)
               report_mismatch("below_minimum", rsp_ch.below_minimum, want.below_minimum);
         end
      end
   end

   // Sends one score item and waits until the core accepts it. Valid stays
   // high after acceptance. The next call either idles or presents a new item,
   // so valid is assigned only once in any time step.
   task automatic send_score(logic [SCORE_BITS-1:0] s, logic closing);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.score <= s;
      req_ch.last  <= closing;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      accumulate_score(s, closing);
   endtask

   // Waits until every expected gene has come back. Then the core is given
   // time to empty its pipeline.
   task automatic drain_genes();
      req_ch.valid <= 1'b0;
      while (expected_genes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(qsa_csr_addr_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         CSR_SQUARE_MODE:   cfg_model.square_mode   = data[0];
         CSR_NEGATIVE_MODE: cfg_model.negative_mode = data[0];
         CSR_MIN_NEEDED:    cfg_model.min_needed    = data;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // The core must be idle before a write, so this drains first. The upper
   // bits of the single-bit mode registers carry random junk.
   task automatic set_modes(bit sq, bit neg, logic [MINREQ_BITS-1:0] min_req);
      logic [CSR_DATA_BITS-1:0] data;
      drain_genes();
      data    = CSR_DATA_BITS'($urandom);
      data[0] = sq;
      write_reg(CSR_SQUARE_MODE, data);
      data    = CSR_DATA_BITS'($urandom);
      data[0] = neg;
      write_reg(CSR_NEGATIVE_MODE, data);
      write_reg(CSR_MIN_NEEDED, min_req);
   endtask

   function automatic logic [SCORE_BITS-1:0] pick_score(int zero_pct);
      if ($urandom_range(0, 99) < zero_pct) return '0;
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return SCORE_BITS'(1);
         2:       return SCORE_BITS'(ZERO_POINT);
         3:       return SCORE_BITS'($urandom_range(ZERO_POINT - 20, ZERO_POINT + 20));
         default: return SCORE_BITS'($urandom_range(1, (1 << SCORE_BITS) - 1));
      endcase
   endfunction

   // This runs with the register values left by reset. Two lone genes are sent:
   // an all-zero gene, which gets the default, and the zero point. One gene has
   // a zero inside, and the divisor must count that item.
   task automatic test_reset_defaults();
      send_score('0, 1'b1);
      send_score('1, 1'b0);
      send_score('0, 1'b0);
      send_score(SCORE_BITS'(1), 1'b1);
      send_score(SCORE_BITS'(ZERO_POINT), 1'b1);
   endtask

   // Square mode and the 640 default. A minimum of zero must act as
   // divide-by-item-count.
   task automatic test_square_negative();
      set_modes(1'b1, 1'b1, '0);
      send_score('1, 1'b1);
      send_score(SCORE_BITS'(1), 1'b0);
      send_score(SCORE_BITS'(ZERO_POINT), 1'b0);
      send_score('0, 1'b1);
      send_score('0, 1'b0);
      send_score('0, 1'b1);
      send_score(SCORE_BITS'(512), 1'b1);
   endtask

   // No gene can reach the largest minimum, so every gene gets the default.
   task automatic test_unreachable_minimum();
      set_modes(1'b0, 1'b1, '1);
      send_score(SCORE_BITS'(5), 1'b0);
      send_score(SCORE_BITS'(6), 1'b1);
      send_score('1, 1'b1);
   endtask

   // A minimum of two: one gene falls short, one meets it, and one is empty.
   task automatic test_minimum_threshold();
      set_modes(1'b1, 1'b0, MINREQ_BITS'(2));
      send_score(SCORE_BITS'(100), 1'b0);
      send_score('0, 1'b1);
      send_score(SCORE_BITS'(100), 1'b0);
      send_score(SCORE_BITS'(900), 1'b1);
      send_score('0, 1'b1);
   endtask

   // Random genes over several register settings. The first phases pin the
   // minimum to 1, the query limit, 0 and one past it. Gene lengths sometimes
   // pass the limit, and runs without zeros let large minimums be met at times.
   task automatic test_random_genes();
      int                       phase_items;
      int                       len;
      int                       zero_pct;
      logic [MINREQ_BITS-1:0]   min_req;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       min_req = MINREQ_BITS'(1);
            1:       min_req = MINREQ_BITS'(MAX_QUERIES);
            2:       min_req = '0;
            3:       min_req = MINREQ_BITS'(MAX_QUERIES + 1);
            default: min_req = ($urandom_range(0, 3) == 0) ? MINREQ_BITS'($urandom)
                                                          : MINREQ_BITS'($urandom_range(1, 12));
         endcase
         if (p < 4)
            set_modes(p[0], p[1], min_req);
         else
            set_modes($urandom_range(0, 1), $urandom_range(0, 1), min_req);
         steady      = (p == STEADY_PHASE);
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASES) begin
            case ($urandom_range(0, 19))
               0, 1, 2:    len = $urandom_range(MAX_QUERIES - 4, MAX_QUERIES + 8);
               3, 4, 5, 6: len = $urandom_range(11, 40);
               default:    len = $urandom_range(1, 10);
            endcase
            case ($urandom_range(0, 2))
               0:       zero_pct = 0;
               1:       zero_pct = 15;
               default: zero_pct = 60;
            endcase
            for (int i = 0; i < len; i++)
               send_score(pick_score(zero_pct), i == len - 1);
            phase_items += len;
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.score  <= '0;
      req_ch.last   <= 1'b0;
      csr_ch.valid  <= 1'b0;
      csr_ch.addr   <= CSR_SQUARE_MODE;
      csr_ch.wdata  <= '0;
      cfg_model.square_mode   = 1'b0;
      cfg_model.negative_mode = 1'b0;
      cfg_model.min_needed    = MINREQ_BITS'(1);
      gene_sum     = '0;
      gene_nonzero = 0;
      gene_items   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_square_negative();
      test_unreachable_minimum();
      test_minimum_threshold();
      test_random_genes();

      drain_genes();
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
